### hdl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, constants and fixed-point helpers for the great-circle
// distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int QW           = 34;
    localparam int SQRT_STEPS   = 31;

    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [30:0]   t_udeg;

    localparam t_udeg UDEG_90  = 31'sd90000000;
    localparam t_udeg UDEG_180 = 31'sd180000000;
    localparam t_udeg UDEG_360 = 31'sd360000000;

    localparam t_q          ONE_Q30  = 34'sd1073741824;
    localparam t_q          PI_Q30   = 34'sd3373259426;
    localparam logic [34:0] DEG2RAD  = 35'd20122276272;
    localparam logic [27:0] DIST_MAX = 28'd205887416;

    localparam logic [15:0] RADIUS_RESET = 16'd6371;
    localparam logic [9:0]  M_PER_KM     = 10'd1000;

    function automatic t_q atan_q30(input int i);
        t_q v;
        case (i)
            0:       v = 34'sd843314857;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043837;
            3:       v = 34'sd133525159;
            4:       v = 34'sd67021687;
            5:       v = 34'sd33543516;
            6:       v = 34'sd16775851;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194283;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048576;
            default: v = (i <= 30) ? (34'sd1 <<< (30 - i)) : 34'sd0;
        endcase
        return v;
    endfunction

    function automatic t_q gain_inv();
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        p = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (2 * i < 64) begin
                p = p + (p >> (2 * i));
            end
        end
        v = p;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        num = (64'd1 << 60) + (r >> 1);
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[62:0], num[k]};
            if (rem >= r) begin
                rem    = rem - r;
                quo[k] = 1'b1;
            end
        end
        return t_q'(quo);
    endfunction

    localparam t_q GAIN_INV = gain_inv();

    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        p = p + 68'sd536870912;
        return t_q'(p >>> 30);
    endfunction

endpackage

### hdl/gcd_front.sv
// ----------------------------------------------------------------------------
// gcd_front
// Angle reduction and microdegree to Q30 radian conversion for three lanes.
// ----------------------------------------------------------------------------
module gcd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [27:0] i_lat_a,
    input  logic signed [28:0] i_lon_a,
    input  logic signed [27:0] i_lat_b,
    input  logic signed [28:0] i_lon_b,
    output logic               o_valid,
    output gcd_pkg::t_q        o_z [3],
    output logic               o_negc [3]
);
    import gcd_pkg::*;

    logic [4:0] r_vld;
    t_udeg       r_a0 [3];
    t_udeg       r_a1 [3];
    logic [26:0] r_mag [3];
    logic        r_nega2 [3];
    logic        r_negc2 [3];
    logic [44:0] r_pl [3];
    logic [43:0] r_ph [3];
    logic        r_nega3 [3];
    logic        r_negc3 [3];
    t_q          r_z [3];
    logic        r_negc4 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a0[0] <= t_udeg'(i_lat_a);
            r_a0[1] <= t_udeg'(i_lat_b);
            r_a0[2] <= t_udeg'(i_lon_a) - t_udeg'(i_lon_b);
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        t_udeg       n_f;
        logic        n_nc;
        logic [62:0] n_sum;

        always_comb begin
            n_nc = 1'b0;
            n_f  = r_a1[l];
            if (r_a1[l] > UDEG_90) begin
                n_f  = UDEG_180 - r_a1[l];
                n_nc = 1'b1;
            end else if (r_a1[l] < -UDEG_90) begin
                n_f  = -UDEG_180 - r_a1[l];
                n_nc = 1'b1;
            end
            n_sum = {1'b0, r_ph[l], 18'b0} + 63'(r_pl[l]) + (63'd1 << 29);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_a0[l] > UDEG_180) begin
                    r_a1[l] <= r_a0[l] - UDEG_360;
                end else if (r_a0[l] < -UDEG_180) begin
                    r_a1[l] <= r_a0[l] + UDEG_360;
                end else begin
                    r_a1[l] <= r_a0[l];
                end
                r_mag[l]   <= 27'(n_f < 0 ? -n_f : n_f);
                r_nega2[l] <= n_f < 0;
                r_negc2[l] <= n_nc;
                r_pl[l]    <= r_mag[l] * DEG2RAD[17:0];
                r_ph[l]    <= r_mag[l] * DEG2RAD[34:18];
                r_nega3[l] <= r_nega2[l];
                r_negc3[l] <= r_negc2[l];
                r_z[l]     <= r_nega3[l] ? -signed'({1'b0, n_sum[62:30]})
                                         : signed'({1'b0, n_sum[62:30]});
                r_negc4[l] <= r_negc3[l];
            end
        end

        assign o_z[l]    = r_z[l];
        assign o_negc[l] = r_negc4[l];
    end

    assign o_valid = r_vld[4];

endmodule

### hdl/gcd_sincos.sv
// ----------------------------------------------------------------------------
// gcd_sincos
// Rotation-mode CORDIC, one step per register stage, giving sine and cosine.
// ----------------------------------------------------------------------------
module gcd_sincos (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  gcd_pkg::t_q i_z,
    input  logic        i_negc,
    output logic        o_valid,
    output gcd_pkg::t_q o_sin,
    output gcd_pkg::t_q o_cos
);
    import gcd_pkg::*;

    logic r_vld [CORDIC_STEPS];
    t_q   r_x [CORDIC_STEPS];
    t_q   r_y [CORDIC_STEPS];
    t_q   r_z [CORDIC_STEPS];
    logic r_nc [CORDIC_STEPS];
    logic r_out_vld;
    t_q   r_sin;
    t_q   r_cos;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        t_q   x_in;
        t_q   y_in;
        t_q   z_in;
        logic v_in;
        logic c_in;

        if (k == 0) begin : g_first
            assign x_in = GAIN_INV;
            assign y_in = '0;
            assign z_in = i_z;
            assign v_in = i_valid;
            assign c_in = i_negc;
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
            assign v_in = r_vld[k-1];
            assign c_in = r_nc[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (z_in >= 0) begin
                    r_x[k] <= x_in - (y_in >>> k);
                    r_y[k] <= y_in + (x_in >>> k);
                    r_z[k] <= z_in - atan_q30(k);
                end else begin
                    r_x[k] <= x_in + (y_in >>> k);
                    r_y[k] <= y_in - (x_in >>> k);
                    r_z[k] <= z_in + atan_q30(k);
                end
                r_nc[k] <= c_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_y[CORDIC_STEPS-1];
            r_cos <= r_nc[CORDIC_STEPS-1] ? -r_x[CORDIC_STEPS-1] : r_x[CORDIC_STEPS-1];
        end
    end

    assign o_valid = r_out_vld;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

### hdl/gcd_term.sv
// ----------------------------------------------------------------------------
// gcd_term
// Law of cosines term with clamping, then a pipelined square root of 1 - t^2.
// ----------------------------------------------------------------------------
module gcd_term (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  gcd_pkg::t_q i_sa,
    input  gcd_pkg::t_q i_ca,
    input  gcd_pkg::t_q i_sb,
    input  gcd_pkg::t_q i_cb,
    input  gcd_pkg::t_q i_cd,
    output logic        o_valid,
    output logic        o_tneg,
    output logic [30:0] o_tabs,
    output logic [30:0] o_root
);
    import gcd_pkg::*;

    logic [3:0]  r_vld;
    t_q          r_q1;
    t_q          r_q2;
    t_q          r_cd;
    t_q          r_t;
    logic        r_tneg3;
    logic [30:0] r_tabs3;
    t_q          n_tc;

    logic        r_svld [SQRT_STEPS+1];
    logic [61:0] r_v [SQRT_STEPS+1];
    logic [61:0] r_r [SQRT_STEPS+1];
    logic        r_sneg [SQRT_STEPS+1];
    logic [30:0] r_sabs [SQRT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_comb begin
        n_tc = r_t;
        if (r_t > ONE_Q30) begin
            n_tc = ONE_Q30;
        end else if (r_t < -ONE_Q30) begin
            n_tc = -ONE_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1    <= qmul(i_sa, i_sb);
            r_q2    <= qmul(i_ca, i_cb);
            r_cd    <= i_cd;
            r_t     <= r_q1 + qmul(r_q2, r_cd);
            r_tneg3 <= n_tc < 0;
            r_tabs3 <= 31'(n_tc < 0 ? -n_tc : n_tc);
        end
    end

    assign r_svld[0] = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]    <= (62'd1 << 60) - {31'b0, r_tabs3} * {31'b0, r_tabs3};
            r_r[0]    <= '0;
            r_sneg[0] <= r_tneg3;
            r_sabs[0] <= r_tabs3;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
        localparam logic [61:0] B = 62'd1 << (60 - 2 * k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_svld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_svld[k+1] <= r_svld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_v[k] >= r_r[k] + B) begin
                    r_v[k+1] <= r_v[k] - (r_r[k] + B);
                    r_r[k+1] <= (r_r[k] >> 1) + B;
                end else begin
                    r_v[k+1] <= r_v[k];
                    r_r[k+1] <= r_r[k] >> 1;
                end
                r_sneg[k+1] <= r_sneg[k];
                r_sabs[k+1] <= r_sabs[k];
            end
        end
    end

    assign o_valid = r_svld[SQRT_STEPS];
    assign o_tneg  = r_sneg[SQRT_STEPS];
    assign o_tabs  = r_sabs[SQRT_STEPS];
    assign o_root  = r_r[SQRT_STEPS][30:0];

endmodule

### hdl/gcd_acos.sv
// ----------------------------------------------------------------------------
// gcd_acos
// Vectoring-mode CORDIC for the arc cosine, then scaling by the radius.
// ----------------------------------------------------------------------------
module gcd_acos (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic        i_tneg,
    input  logic [30:0] i_tabs,
    input  logic [30:0] i_root,
    input  logic [25:0] i_radius_m,
    output logic        o_valid,
    output logic [27:0] o_distance_m
);
    import gcd_pkg::*;

    logic r_vld [CORDIC_STEPS];
    t_q   r_x [CORDIC_STEPS];
    t_q   r_y [CORDIC_STEPS];
    t_q   r_z [CORDIC_STEPS];
    logic r_tn [CORDIC_STEPS];

    logic [2:0]  r_fvld;
    logic [31:0] r_ang;
    logic [57:0] r_prod;
    logic [27:0] r_dist;
    t_q          n_zz;
    logic [58:0] n_sum;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        t_q   x_in;
        t_q   y_in;
        t_q   z_in;
        logic v_in;
        logic n_in;

        if (k == 0) begin : g_first
            assign x_in = signed'({3'b0, i_tabs});
            assign y_in = signed'({3'b0, i_root});
            assign z_in = '0;
            assign v_in = i_valid;
            assign n_in = i_tneg;
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
            assign v_in = r_vld[k-1];
            assign n_in = r_tn[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (y_in > 0) begin
                    r_x[k] <= x_in + (y_in >>> k);
                    r_y[k] <= y_in - (x_in >>> k);
                    r_z[k] <= z_in + atan_q30(k);
                end else begin
                    r_x[k] <= x_in - (y_in >>> k);
                    r_y[k] <= y_in + (x_in >>> k);
                    r_z[k] <= z_in - atan_q30(k);
                end
                r_tn[k] <= n_in;
            end
        end
    end

    always_comb begin
        n_zz  = r_tn[CORDIC_STEPS-1] ? PI_Q30 - r_z[CORDIC_STEPS-1] : r_z[CORDIC_STEPS-1];
        n_sum = {1'b0, r_prod} + (59'd1 << 29);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= '0;
        end else if (i_en) begin
            r_fvld <= {r_fvld[1:0], r_vld[CORDIC_STEPS-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_zz < 0) begin
                r_ang <= '0;
            end else if (n_zz > PI_Q30) begin
                r_ang <= PI_Q30[31:0];
            end else begin
                r_ang <= n_zz[31:0];
            end
            r_prod <= r_ang * i_radius_m;
            if (n_sum[58:30] > {1'b0, DIST_MAX}) begin
                r_dist <= DIST_MAX;
            end else begin
                r_dist <= n_sum[57:30];
            end
        end
    end

    assign o_valid      = r_fvld[2];
    assign o_distance_m = r_dist;

endmodule

### hdl/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance
// Great-circle distance between two points on a sphere, fully pipelined.
// ----------------------------------------------------------------------------
// The block accepts one point pair per clock while o_ready is high and
// returns its distance in metres. The path runs through two CORDIC
// pipelines of one step per stage and a square root pipeline of one result
// bit per stage. A two-entry output buffer keeps accepting beats while a
// result waits; the whole pipeline holds only once both entries are full.
// The radius register may be written at any time the block is idle and
// takes effect on the next pair.
module great_circle_distance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_radius_km,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [27:0] i_lat_a,
    input  logic signed [28:0] i_lon_a,
    input  logic signed [27:0] i_lat_b,
    input  logic signed [28:0] i_lon_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [27:0]        o_distance_m
);
    import gcd_pkg::*;

    logic [25:0] r_radius_m;
    logic        r_out_vld;
    logic        r_skid_vld;
    logic [27:0] r_out;
    logic [27:0] r_skid;
    logic        w_en;

    logic        w_f_vld;
    t_q          w_z [3];
    logic        w_negc [3];
    logic        w_sc_vld [3];
    t_q          w_sin [3];
    t_q          w_cos [3];
    logic        w_t_vld;
    logic        w_tneg;
    logic [30:0] w_tabs;
    logic [30:0] w_root;
    logic        w_a_vld;
    logic [27:0] w_dist;

    assign w_en        = !r_skid_vld;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_m <= 26'(RADIUS_RESET) * 26'(M_PER_KM);
        end else if (i_cfg_valid) begin
            r_radius_m <= 26'(i_radius_km) * 26'(M_PER_KM);
        end
    end

    gcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_lat_a (i_lat_a),
        .i_lon_a (i_lon_a),
        .i_lat_b (i_lat_b),
        .i_lon_b (i_lon_b),
        .o_valid (w_f_vld),
        .o_z     (w_z),
        .o_negc  (w_negc)
    );

    for (genvar l = 0; l < 3; l++) begin : g_sc
        gcd_sincos u_sincos (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_f_vld),
            .i_z     (w_z[l]),
            .i_negc  (w_negc[l]),
            .o_valid (w_sc_vld[l]),
            .o_sin   (w_sin[l]),
            .o_cos   (w_cos[l])
        );
    end

    gcd_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sc_vld[0] & w_sc_vld[1] & w_sc_vld[2]),
        .i_sa    (w_sin[0]),
        .i_ca    (w_cos[0]),
        .i_sb    (w_sin[1]),
        .i_cb    (w_cos[1]),
        .i_cd    (w_cos[2]),
        .o_valid (w_t_vld),
        .o_tneg  (w_tneg),
        .o_tabs  (w_tabs),
        .o_root  (w_root)
    );

    gcd_acos u_acos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_t_vld),
        .i_tneg       (w_tneg),
        .i_tabs       (w_tabs),
        .i_root       (w_root),
        .i_radius_m   (r_radius_m),
        .o_valid      (w_a_vld),
        .o_distance_m (w_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_a_vld) begin
            if (!r_out_vld || i_ready) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (w_a_vld) begin
            if (!r_out_vld || i_ready) begin
                r_out <= w_dist;
            end else begin
                r_skid <= w_dist;
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_distance_m = r_out;

endmodule
